@@ sv/tcm_pkg.sv @@
package tcm_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  // register field widths
  localparam int IMG_W_BITS  = 11;
  localparam int IMG_H_BITS  = 13;
  localparam int THR_BITS    = 8;
  localparam int CFG_DW      = 13;
  localparam int CFG_IDX_W   = 2;

  // reset values of the registers
  localparam int WIDTH_RESET  = 512;
  localparam int HEIGHT_RESET = 512;
  localparam logic [THR_BITS-1:0] THR_RESET = 8'd127;
  localparam int MIN_SIZE = 3;

  // pixel and result field widths
  localparam int PIX_W     = 8;
  localparam int OUT_ROW_W = 12;
  localparam int OUT_COL_W = 10;

  // row store entry: bit 0 row r-1, bit 1 row r-2
  localparam int ENT_W = 2;

  localparam int OFIFO_DEPTH = 4;
  localparam int OFIFO_PW    = $clog2(OFIFO_DEPTH);
  localparam int OFIFO_CW    = $clog2(OFIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMG_WIDTH  = 2'd0,
    REG_IMG_HEIGHT = 2'd1,
    REG_THRESHOLD  = 2'd2,
    REG_MODE       = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    MODE_DILATE = 1'b0,
    MODE_ERODE  = 1'b1
  } mode_t;

  typedef struct packed {
    logic                 set;
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
    logic                 last;
  } res_t;

  typedef struct packed {
    logic [OFIFO_CW-1:0] count;
    logic                not_empty;
  } ofifo_stat_t;

endpackage

@@ sv/tcm_ram.sv @@
module tcm_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

@@ sv/tcm_ofifo.sv @@
module tcm_ofifo
  import tcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push0,
  input  res_t        din0,
  input  logic        push1,
  input  res_t        din1,
  input  logic        pop,
  output res_t        dout,
  output ofifo_stat_t stat
);

  res_t                mem_r [OFIFO_DEPTH];
  logic [OFIFO_PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OFIFO_PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OFIFO_CW-1:0] count_r, count_nxt;
  logic [OFIFO_CW-1:0] n_push;
  logic                do_pop;

  // push1 only comes along with push0; it lands in the slot after din0
  always_ff @(posedge clk) begin
    if (push0) begin
      mem_r[wr_ptr_r] <= din0;
    end
    if (push1) begin
      mem_r[wr_ptr_r + OFIFO_PW'(1)] <= din1;
    end
  end

  always_comb begin
    do_pop = pop && (count_r != '0);
    n_push = push1 ? OFIFO_CW'(2) : (push0 ? OFIFO_CW'(1) : '0);
    wr_ptr_nxt = wr_ptr_r + OFIFO_PW'(n_push);
    rd_ptr_nxt = do_pop ? rd_ptr_r + OFIFO_PW'(1) : rd_ptr_r;
    count_nxt  = count_r + n_push - (do_pop ? OFIFO_CW'(1) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign dout           = mem_r[rd_ptr_r];
  assign stat.count     = count_r;
  assign stat.not_empty = (count_r != '0);

endmodule

@@ sv/threshold_cross_morphology.sv @@
// Streaming 3x3 cross morphology on a thresholded grayscale frame.
// Input channel: in_valid / in_stall / in_gray_pixel, one pixel per transfer,
// raster order. Result channel: out_valid / out_stall with out_set, out_row,
// out_col, out_last_of_run. A pixel at row r >= 1 gives the result for
// (r-1, c); a last-row pixel also gives (r, c) as a second result. Row 0
// gives nothing. Config (cfg_we, cfg_index, cfg_wdata) must be written only
// while the block is idle; the block itself does not enforce this. A size
// write restarts the frame. Throughput: one pixel per cycle while in_stall
// is low; on the last row each pixel gives two results, which leave through
// the single result port. The first result of a pixel passes the read stage
// (row store read), then the 4-entry result queue. The row store is a
// 2-bit-wide RAM kept in two copies so that columns c and c+1 are read in the
// same cycle. in_stall rises when the result queue may not hold what is in
// flight; a stalled receiver therefore backs up to the input and nothing is
// lost. Reset restores the register defaults and the frame counters; row
// store contents are not cleared (row 0 fills them).
module threshold_cross_morphology
  import tcm_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     in_gray_pixel,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_set,
  output logic [OUT_ROW_W-1:0] out_row,
  output logic [OUT_COL_W-1:0] out_col,
  output logic                 out_last_of_run,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int W_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
  localparam int H_RST = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

  // registers
  logic [WW-1:0]       width_r;
  logic [HW-1:0]       height_r;
  logic [THR_BITS-1:0] thr_r;
  mode_t               mode_r;

  // frame position
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          window_r;

  // read stage
  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_gray_r;
  logic [CW-1:0]    s1_col_r;
  logic [RW-1:0]    s1_row_r;
  logic             s1_first_r, s1_lastrow_r, s1_int_cur_r, s1_int_res_r;
  logic             s1_has_left_r, s1_has_right_r;

  logic [31:0]      wv, hv, w_clamp, h_clamp;
  logic             size_wr, in_acc;
  logic             col_end, row_end, lastrow_now, col_inner, int_cur, int_res;
  logic [CW-1:0]    rgt_addr;
  logic [ENT_W-1:0] ent_ctr, ent_rgt, ram_wdata;
  logic             up, left, center, right, cur, res_dil, res_ero;
  logic [RW-1:0]    row_m1;
  res_t             res1, res2, head;
  logic             push0, push1, pop;
  ofifo_stat_t      fifo_stat;
  logic [3:0]       n1, n_in, need;

  // ---------------- configuration ----------------
  always_comb begin
    wv = 32'(cfg_wdata[IMG_W_BITS-1:0]);
    hv = 32'(cfg_wdata[IMG_H_BITS-1:0]);
    if (wv < 32'(MIN_SIZE)) begin
      w_clamp = 32'(MIN_SIZE);
    end else if (wv > 32'(MAX_WIDTH)) begin
      w_clamp = 32'(MAX_WIDTH);
    end else begin
      w_clamp = wv;
    end
    if (hv < 32'(MIN_SIZE)) begin
      h_clamp = 32'(MIN_SIZE);
    end else if (hv > 32'(MAX_HEIGHT)) begin
      h_clamp = 32'(MAX_HEIGHT);
    end else begin
      h_clamp = hv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WW'(W_RST);
      height_r <= HW'(H_RST);
      thr_r    <= THR_RESET;
      mode_r   <= MODE_DILATE;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMG_WIDTH:  width_r  <= WW'(w_clamp);
        REG_IMG_HEIGHT: height_r <= HW'(h_clamp);
        REG_THRESHOLD:  thr_r    <= cfg_wdata[THR_BITS-1:0];
        REG_MODE:       mode_r   <= mode_t'(cfg_wdata[0]);
      endcase
    end
  end

  assign size_wr = cfg_we && ((cfg_reg_t'(cfg_index) == REG_IMG_WIDTH) ||
                              (cfg_reg_t'(cfg_index) == REG_IMG_HEIGHT));

  // ---------------- input side ----------------
  assign in_acc = in_valid && !in_stall;

  always_comb begin
    col_end     = (32'(col_r) + 32'd1 >= 32'(width_r));
    row_end     = (32'(row_r) + 32'd1 >= 32'(height_r));
    lastrow_now = (32'(row_r) + 32'd1 == 32'(height_r));
    col_inner   = (col_r != '0) && (32'(col_r) + 32'd2 <= 32'(width_r));
    int_cur     = (row_r != '0) && (32'(row_r) + 32'd2 <= 32'(height_r)) && col_inner;
    int_res     = (32'(row_r) >= 32'd2) && col_inner;
    col_nxt     = col_end ? '0 : col_r + CW'(1);
    row_nxt     = !col_end ? row_r : (row_end ? '0 : row_r + RW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (size_wr) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_gray_r      <= in_gray_pixel;
      s1_col_r       <= col_r;
      s1_row_r       <= row_r;
      s1_first_r     <= (row_r == '0);
      s1_lastrow_r   <= lastrow_now;
      s1_int_cur_r   <= int_cur;
      s1_int_res_r   <= int_res;
      s1_has_left_r  <= (col_r != '0);
      s1_has_right_r <= !col_end;
    end
  end

  // ---------------- row store ----------------
  // Both copies take the same writes; one is read at column c, the other at c+1.
  // The write of column c lands before any later read of it.
  assign rgt_addr  = col_r + CW'(1);
  assign ram_wdata = s1_first_r ? {1'b0, cur} : {center, cur};

  tcm_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_WIDTH)
  ) u_ram_ctr (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_col_r),
    .wdata (ram_wdata),
    .raddr (col_r),
    .rdata (ent_ctr)
  );

  tcm_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_WIDTH)
  ) u_ram_rgt (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_col_r),
    .wdata (ram_wdata),
    .raddr (rgt_addr),
    .rdata (ent_rgt)
  );

  // ---------------- cross window ----------------
  always_comb begin
    center  = ent_ctr[0];
    up      = ent_ctr[1];
    right   = s1_has_right_r && ent_rgt[0];
    left    = s1_has_left_r && window_r;
    cur     = s1_int_cur_r && (s1_gray_r >= thr_r);
    res_dil = up | left | center | right | cur;
    res_ero = s1_int_res_r & up & left & center & right & cur;
    row_m1  = s1_row_r - RW'(1);

    res1.set  = (mode_r == MODE_DILATE) ? res_dil : res_ero;
    res1.row  = OUT_ROW_W'(row_m1);
    res1.col  = OUT_COL_W'(s1_col_r);
    res1.last = !s1_lastrow_r;

    // the last row is all border: only the pixel above can set it
    res2.set  = (mode_r == MODE_DILATE) ? center : 1'b0;
    res2.row  = OUT_ROW_W'(s1_row_r);
    res2.col  = OUT_COL_W'(s1_col_r);
    res2.last = 1'b1;

    push0 = s1_valid_r && !s1_first_r;
    push1 = s1_valid_r && !s1_first_r && s1_lastrow_r;
  end

  // left neighbor: row r-1 bit of the previous column, already overwritten
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= 1'b0;
    end else if (size_wr) begin
      window_r <= 1'b0;
    end else if (s1_valid_r) begin
      window_r <= s1_first_r ? 1'b0 : center;
    end
  end

  // ---------------- result queue ----------------
  assign pop = out_valid && !out_stall;

  tcm_ofifo u_ofifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push0 (push0),
    .din0  (res1),
    .push1 (push1),
    .din1  (res2),
    .pop   (pop),
    .dout  (head),
    .stat  (fifo_stat)
  );

  assign out_valid       = fifo_stat.not_empty;
  assign out_set         = head.set;
  assign out_row         = head.row;
  assign out_col         = head.col;
  assign out_last_of_run = head.last;

  // room for the queue contents, the item in the read stage and a new one
  always_comb begin
    n1       = s1_valid_r ? (s1_lastrow_r ? 4'd2 : 4'd1) : 4'd0;
    n_in     = lastrow_now ? 4'd2 : 4'd1;
    need     = 4'(fifo_stat.count) + n1 + n_in;
    in_stall = !rst_n || (need > 4'(OFIFO_DEPTH));
  end

  // ---------------- checks ----------------
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_stat.count <= OFIFO_CW'(OFIFO_DEPTH))
    else $error("result queue overflow");

  a_lastrow_two: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && lastrow_now) |=> (push0 && push1))
    else $error("last-row pixel did not give two results");

  a_push_src: assert property (@(posedge clk) disable iff (!rst_n)
    push0 |-> $past(in_acc))
    else $error("result without a pixel transfer");

endmodule
